// ----- rtl/rgb2hsl_pkg.sv -----
// Package with the payload types, widths and shared constants of the RGB to HSL converter.
package rgb2hsl_pkg;

    localparam int ChW = 8;
    localparam int OutW = 16;
    // Quotient bits produced by the divider row, one per cell.
    localparam int QBits = 16;
    // Divisors reach 6*255 = 1530, which needs 11 bits.
    localparam int DenW = 11;
    // Dividends reach 1530*65535, which needs 27 bits.
    localparam int NumW = 27;
    localparam int Stages = QBits + 1;

    typedef struct packed {
        logic [ChW-1:0] red;
        logic [ChW-1:0] green;
        logic [ChW-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [OutW-1:0] hue;
        logic [OutW-1:0] saturation;
        logic [OutW-1:0] lightness;
    } t_hsl;

    // One long-division lane: partial remainder, divisor and the quotient so far.
    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QBits-1:0] quo;
    } t_div_lane;

    // Everything one pipeline cell hands to the next.
    typedef struct packed {
        logic valid;
        t_div_lane sat;
        t_div_lane hue;
        logic [OutW-1:0] lightness;
    } t_cell_data;

endpackage

// ----- rtl/rgb2hsl_front.sv -----
// Front cell: finds max and min, forms lightness and the two dividends and divisors.
module rgb2hsl_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  rgb2hsl_pkg::t_pixel     i_pixel,
    output rgb2hsl_pkg::t_cell_data o_data
);
    import rgb2hsl_pkg::*;

    logic [ChW-1:0] mx, mn, r, g, b;
    logic [ChW:0] sum;
    logic [ChW-1:0] d;
    logic [DenW-1:0] sden, hden, num;
    t_cell_data n_data, r_data;

    always_comb begin
        r = i_pixel.red;
        g = i_pixel.green;
        b = i_pixel.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        sum = {1'b0, mx} + {1'b0, mn};
        d = mx - mn;
        sden = (sum < 9'd255) ? {2'b0, sum} : (11'd510 - {2'b0, sum});
        hden = 11'(d) * 11'd6;
        // Hue numerator already wrapped into one turn: 0 .. 6d.
        if (r == mx) begin
            num = (g >= b) ? 11'(g - b) : (hden - 11'(b - g));
        end else if (g == mx) begin
            num = 11'(2 * d) + 11'(b) - 11'(r);
        end else begin
            num = 11'(4 * d) + 11'(r) - 11'(g);
        end
        n_data.valid = i_valid;
        // Lightness is sum*257/2, truncated.
        n_data.lightness = 16'((17'(sum) * 17'd257) >> 1);
        // Grey pixels divide zero by one, which yields zero.
        n_data.sat.rem = (d == '0) ? '0 : NumW'(d) * NumW'(65535);
        n_data.sat.den = (d == '0) ? DenW'(1) : sden;
        n_data.sat.quo = '0;
        n_data.hue.rem = (d == '0) ? '0 : NumW'(num) * NumW'(65535);
        n_data.hue.den = (d == '0) ? DenW'(1) : hden;
        n_data.hue.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= n_data.valid;
        end
        r_data.sat <= n_data.sat;
        r_data.hue <= n_data.hue;
        r_data.lightness <= n_data.lightness;
    end

    assign o_data = r_data;
endmodule

// ----- rtl/rgb2hsl_cell.sv -----
// Divider cell: resolves one quotient bit of both divisions and passes the rest on.
module rgb2hsl_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [3:0]              i_bit,
    input  rgb2hsl_pkg::t_cell_data i_data,
    output rgb2hsl_pkg::t_cell_data o_data
);
    import rgb2hsl_pkg::*;

    t_cell_data n_data, r_data;
    logic [NumW+QBits-1:0] st, ht;

    always_comb begin
        n_data = i_data;
        st = {{QBits{1'b0}}, NumW'(i_data.sat.den)} << i_bit;
        ht = {{QBits{1'b0}}, NumW'(i_data.hue.den)} << i_bit;
        if ({{QBits{1'b0}}, i_data.sat.rem} >= st) begin
            n_data.sat.rem = i_data.sat.rem - NumW'(st);
            n_data.sat.quo[i_bit] = 1'b1;
        end
        if ({{QBits{1'b0}}, i_data.hue.rem} >= ht) begin
            n_data.hue.rem = i_data.hue.rem - NumW'(ht);
            n_data.hue.quo[i_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= n_data.valid;
        end
        r_data.sat <= n_data.sat;
        r_data.hue <= n_data.hue;
        r_data.lightness <= n_data.lightness;
    end

    assign o_data = r_data;
endmodule

// ----- rtl/rgb_to_hsl_converter.sv -----
// Top level of the RGB to HSL converter: front cell followed by a row of divider cells.
// Takes one pixel request every clock (busy is always low) and returns its result
// through the registered front cell and then each of the 16 divider cells in turn,
// each divider cell resolving one quotient bit of saturation and hue together.
// Results appear for one cycle on the o_done strobe and cannot be held off.
module rgb_to_hsl_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rgb2hsl_pkg::t_pixel i_pixel,
    output logic                o_done,
    output rgb2hsl_pkg::t_hsl   o_hsl
);
    import rgb2hsl_pkg::*;

    t_cell_data chain [0:QBits];

    assign busy = 1'b0;

    rgb2hsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_pixel (i_pixel),
        .o_data  (chain[0])
    );

    for (genvar k = 0; k < QBits; k++) begin : g_cell
        rgb2hsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (4'(QBits - 1 - k)),
            .i_data  (chain[k]),
            .o_data  (chain[k+1])
        );
    end

    assign o_done = chain[QBits].valid;
    assign o_hsl.hue = chain[QBits].hue.quo;
    assign o_hsl.saturation = chain[QBits].sat.quo;
    assign o_hsl.lightness = chain[QBits].lightness;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(Stages) o_done)
        else $error("request did not complete after the pipeline latency");
    a_hue_below_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hsl.hue != 16'hFFFF))
        else $error("hue reached a full turn");
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (chain[QBits].sat.quo == '0) |-> (o_hsl.hue == '0))
        else $error("zero saturation with non-zero hue");
endmodule

// ----- tb/rgb_to_hsl_converter_tb.sv -----
// Testbench for the RGB to HSL converter: queued pixel driver, strobe monitor and predictor.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
    import rgb2hsl_pkg::*;

    localparam int RandPixels = 950;
    localparam int WatchLimit = 2000;
    localparam int Latency = 17;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_pixel i_pixel = '0;
    logic o_done;
    t_hsl o_hsl;

    t_pixel pending_pixels[$];
    t_hsl expected_hsl[$];
    int mismatches = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int watch_count = 0;
    bit calm_phase = 1'b0;

    rgb_to_hsl_converter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel(i_pixel), .o_done(o_done), .o_hsl(o_hsl)
    );

    always #1 i_clk = ~i_clk;

    // Exact integer conversion, truncated once at the end.
    function automatic t_hsl convert_pixel(t_pixel p);
        t_hsl res;
        int r, g, b, mx, mn, sum, d, den, num;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        sum = mx + mn;
        res.lightness = 16'((longint'(sum) * 65535) / 510);
        res.hue = '0;
        res.saturation = '0;
        if (mx != mn) begin
            d = mx - mn;
            den = (sum < 255) ? sum : (510 - sum);
            res.saturation = 16'((longint'(d) * 65535) / den);
            if (r == mx) num = g - b;
            else if (g == mx) num = 2 * d + b - r;
            else num = 4 * d + r - g;
            if (num < 0) num += 6 * d;
            res.hue = 16'((longint'(num) * 65535) / (6 * d));
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, want);
    endtask

    task automatic queue_pixel(int r, int g, int b);
        t_pixel p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        pending_pixels.push_back(p);
    endtask

    // Driver: one request per edge unless a random idle burst is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_hsl.push_back(convert_pixel(i_pixel));
                pixels_sent++;
            end
            if (start && busy) begin
                // Request not yet taken: hold it.
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                start <= 1'b0;
                idle_cycles++;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 9);
                start <= 1'b0;
                idle_cycles++;
            end else if (pending_pixels.size() > 0) begin
                i_pixel <= pending_pixels.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_hsl.size() == 0) begin
                    report_mismatch("unexpected", 1, 0);
                end else begin
                    t_hsl want;
                    want = expected_hsl.pop_front();
                    if (o_hsl.hue !== want.hue) report_mismatch("hue", o_hsl.hue, want.hue);
                    if (o_hsl.saturation !== want.saturation)
                        report_mismatch("saturation", o_hsl.saturation, want.saturation);
                    if (o_hsl.lightness !== want.lightness)
                        report_mismatch("lightness", o_hsl.lightness, want.lightness);
                end
                results_seen++;
            end
            if (o_done || (start && !busy)) watch_count <= 0;
            else watch_count <= watch_count + 1;
            if (watch_count >= WatchLimit) begin
                $display("Watchdog expired with %0d results outstanding", expected_hsl.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int edges[6] = '{0, 1, 127, 128, 254, 255};
        int k, r, g, b;
        // Greys at the extremes, pure and secondary colours, ties and half lightness.
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(255, 0, 255);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 1);
        queue_pixel(200, 100, 200);
        queue_pixel(1, 0, 0);
        queue_pixel(255, 254, 254);
        queue_pixel(200, 55, 100);
        queue_pixel(128, 127, 127);
        queue_pixel(127, 128, 127);
        queue_pixel(10, 20, 245);
        queue_pixel(170, 85, 255);
        queue_pixel(0, 1, 1);
        queue_pixel(254, 255, 255);
        for (k = 0; k < RandPixels; k++) begin
            case ($urandom_range(0, 3))
                0: begin
                    r = edges[$urandom_range(0, 5)];
                    g = edges[$urandom_range(0, 5)];
                    b = edges[$urandom_range(0, 5)];
                end
                1: begin
                    // Two channels tied, exercising the priority of the largest.
                    r = $urandom_range(0, 255);
                    g = ($urandom_range(0, 1)) ? r : $urandom_range(0, 255);
                    b = ($urandom_range(0, 1)) ? g : r;
                end
                default: begin
                    r = $urandom_range(0, 255);
                    g = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
            endcase
            queue_pixel(r, g, b);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_pixels.size() < 150);
        calm_phase = 1'b1;
        wait (pending_pixels.size() == 0 && !start);
        wait (expected_hsl.size() == 0);
        repeat (Latency + 5) @(posedge i_clk);
        $display("Sent %0d pixels with %0d idle cycles; checked %0d results.",
                 pixels_sent, idle_cycles, results_seen);
        if (mismatches == 0 && expected_hsl.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- rgb_to_hsl_converter.f -----
rtl/rgb2hsl_pkg.sv
rtl/rgb2hsl_front.sv
rtl/rgb2hsl_cell.sv
rtl/rgb_to_hsl_converter.sv
tb/rgb_to_hsl_converter_tb.sv
